FILE: hw/rtl/refcounted_handle_cache_assert.svh
// Assertion macros used by the handle cache RTL (rhc_ctrl).
`ifndef REFCOUNTED_HANDLE_CACHE_ASSERT_SVH
`define REFCOUNTED_HANDLE_CACHE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RHC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rhc_pkg.sv
// Shared types and constants of the handle cache.
package rhc_pkg;

    localparam int ID_W     = 64;
    localparam int SLOT_W   = 5;
    localparam int REFOUT_W = 8;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_FILL     = 3'd1,
        ST_FULL     = 3'd2,
        ST_REL      = 3'd3,
        ST_REL_NONE = 3'd4,
        ST_SAT      = 3'd5
    } t_status;

    typedef struct packed {
        t_status               status;
        logic [SLOT_W-1:0]     slot_index;
        logic [REFOUT_W-1:0]   ref_after;
        logic                  replaced;
        logic [ID_W-1:0]       replaced_id;
        logic                  replaced_write;
    } t_result;

endpackage

FILE: hw/rtl/refcounted_handle_cache.sv
// Reference-counted handle cache with round-robin replacement: acquire
// looks up (object_id, want_write), raising the count on an unsaturated hit
// or refilling the first unreferenced entry from the advanced cursor onward,
// wrapping around, on a miss; release drops the count of one entry. One item
// is in work at a time. An acquire reads the table one row per cycle through
// its single read port and one compare unit, stopping at the first matching
// entry; a miss reads every entry. The result waits in an output register,
// so the next item is taken while it is still unclaimed.
module refcounted_handle_cache #(
    parameter int ENTRIES  = 32,
    parameter int REF_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_op,
    input  logic [rhc_pkg::ID_W-1:0]         i_object_id,
    input  logic                             i_want_write,
    input  logic [rhc_pkg::SLOT_W-1:0]       i_release_slot,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [2:0]                       o_status,
    output logic [rhc_pkg::SLOT_W-1:0]       o_slot_index,
    output logic [rhc_pkg::REFOUT_W-1:0]     o_ref_after,
    output logic                             o_replaced,
    output logic [rhc_pkg::ID_W-1:0]         o_replaced_id,
    output logic                             o_replaced_write
);

    localparam int IW = $clog2(ENTRIES);

    logic                       rd_en;
    logic [IW-1:0]              rd_addr;
    logic                       rd_valid;
    logic [rhc_pkg::ID_W-1:0]   rd_id;
    logic                       rd_write;
    logic [REF_BITS-1:0]        rd_refs;
    logic                       wr_en;
    logic [IW-1:0]              wr_addr;
    logic [rhc_pkg::ID_W-1:0]   wr_id;
    logic                       wr_write;
    logic [REF_BITS-1:0]        wr_refs;
    logic                       res_valid;
    rhc_pkg::t_result           res;
    logic                       out_free;
    logic                       r_out_valid;
    rhc_pkg::t_result           r_out;

    rhc_table #(
        .ENTRIES  (ENTRIES),
        .REF_BITS (REF_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_valid (rd_valid),
        .o_rd_id    (rd_id),
        .o_rd_write (rd_write),
        .o_rd_refs  (rd_refs),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_id    (wr_id),
        .i_wr_write (wr_write),
        .i_wr_refs  (wr_refs)
    );

    rhc_ctrl #(
        .ENTRIES  (ENTRIES),
        .REF_BITS (REF_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_in_ready     (o_ready),
        .i_op           (i_op),
        .i_object_id    (i_object_id),
        .i_want_write   (i_want_write),
        .i_release_slot (i_release_slot),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_valid     (rd_valid),
        .i_rd_id        (rd_id),
        .i_rd_write     (rd_write),
        .i_rd_refs      (rd_refs),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_id        (wr_id),
        .o_wr_write     (wr_write),
        .o_wr_refs      (wr_refs),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .i_out_free     (out_free)
    );

    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_slot_index     = r_out.slot_index;
    assign o_ref_after      = r_out.ref_after;
    assign o_replaced       = r_out.replaced;
    assign o_replaced_id    = r_out.replaced_id;
    assign o_replaced_write = r_out.replaced_write;

endmodule

FILE: hw/rtl/rhc_table.sv
// Entry table: one-read one-write row memory plus per-entry valid bits.
module rhc_table #(
    parameter int ENTRIES  = 32,
    parameter int REF_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [$clog2(ENTRIES)-1:0]  i_rd_addr,
    output logic                        o_rd_valid,
    output logic [rhc_pkg::ID_W-1:0]    o_rd_id,
    output logic                        o_rd_write,
    output logic [REF_BITS-1:0]         o_rd_refs,
    input  logic                        i_wr_en,
    input  logic [$clog2(ENTRIES)-1:0]  i_wr_addr,
    input  logic [rhc_pkg::ID_W-1:0]    i_wr_id,
    input  logic                        i_wr_write,
    input  logic [REF_BITS-1:0]         i_wr_refs
);

    localparam int ROW_W = rhc_pkg::ID_W + 1 + REF_BITS;

    logic [ROW_W-1:0]   mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [ROW_W-1:0]   r_rd_row;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= {i_wr_id, i_wr_write, i_wr_refs};
        end
        if (i_rd_en) begin
            r_rd_row <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // Empty entries read as count zero and never match.
    assign o_rd_valid = r_rd_valid;
    assign o_rd_id    = r_rd_row[ROW_W-1 -: rhc_pkg::ID_W];
    assign o_rd_write = r_rd_row[REF_BITS];
    assign o_rd_refs  = r_rd_valid ? r_rd_row[REF_BITS-1:0] : '0;

endmodule

FILE: hw/rtl/rhc_ctrl.sv
// Sequencer: scans the table through one compare unit and builds each result.
`include "refcounted_handle_cache_assert.svh"

module rhc_ctrl #(
    parameter int ENTRIES  = 32,
    parameter int REF_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_in_ready,
    input  logic                            i_op,
    input  logic [rhc_pkg::ID_W-1:0]        i_object_id,
    input  logic                            i_want_write,
    input  logic [rhc_pkg::SLOT_W-1:0]      i_release_slot,
    output logic                            o_rd_en,
    output logic [$clog2(ENTRIES)-1:0]      o_rd_addr,
    input  logic                            i_rd_valid,
    input  logic [rhc_pkg::ID_W-1:0]        i_rd_id,
    input  logic                            i_rd_write,
    input  logic [REF_BITS-1:0]             i_rd_refs,
    output logic                            o_wr_en,
    output logic [$clog2(ENTRIES)-1:0]      o_wr_addr,
    output logic [rhc_pkg::ID_W-1:0]        o_wr_id,
    output logic                            o_wr_write,
    output logic [REF_BITS-1:0]             o_wr_refs,
    output logic                            o_res_valid,
    output rhc_pkg::t_result                o_res,
    input  logic                            i_out_free
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0]       LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [REF_BITS-1:0] REF_MAX  = {REF_BITS{1'b1}};
    localparam logic [REF_BITS-1:0] REF_ONE  = REF_BITS'(1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_REL  = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                     r_state, n_state;
    logic                       r_op;
    logic [rhc_pkg::ID_W-1:0]   r_key_id;
    logic                       r_key_wr;
    logic [rhc_pkg::SLOT_W-1:0] r_rslot;
    logic                       r_bad;
    logic [IW-1:0]              r_cursor, n_cursor;
    logic [IW-1:0]              r_base;
    logic [IW-1:0]              r_addr;
    logic                       r_issue_done;
    logic                       r_pend;
    logic [IW-1:0]              r_pidx;
    logic                       r_hit;
    logic [IW-1:0]              r_sel_idx;
    logic [REF_BITS-1:0]        r_sel_refs;
    logic [rhc_pkg::ID_W-1:0]   r_sel_id;
    logic                       r_sel_wr;
    logic                       r_have_hi, r_have_lo;
    logic [IW-1:0]              r_hi_idx, r_lo_idx;
    logic                       r_hi_vld, r_lo_vld;
    logic [rhc_pkg::ID_W-1:0]   r_hi_id, r_lo_id;
    logic                       r_hi_wr, r_lo_wr;
    rhc_pkg::t_result           r_res, n_res;

    logic                       accept;
    logic                       rel_in_range;
    logic [IW-1:0]              base_next;
    logic                       row_match;
    logic                       row_zero;
    logic                       fill_valid;
    logic [IW-1:0]              fill_idx;
    logic                       fill_vld;
    logic [rhc_pkg::ID_W-1:0]   fill_id;
    logic                       fill_wr;
    logic [REF_BITS-1:0]        refs_dec;
    logic [REF_BITS-1:0]        refs_inc;

    assign o_in_ready   = (r_state == S_IDLE);
    assign accept       = i_valid && o_in_ready;
    assign rel_in_range = (32'(i_release_slot) < ENTRIES);
    assign base_next    = (r_cursor == LAST_IDX) ? '0 : r_cursor + 1'b1;

    // Shared compare unit on the row just read.
    assign row_match = i_rd_valid && (i_rd_id == r_key_id) && (i_rd_write == r_key_wr);
    assign row_zero  = (i_rd_refs == '0);

    assign refs_dec = r_sel_refs - 1'b1;
    assign refs_inc = r_sel_refs + 1'b1;

    always_comb begin
        fill_valid = r_have_hi || r_have_lo;
        if (r_have_hi) begin
            fill_idx = r_hi_idx;
            fill_vld = r_hi_vld;
            fill_id  = r_hi_id;
            fill_wr  = r_hi_wr;
        end else begin
            fill_idx = r_lo_idx;
            fill_vld = r_lo_vld;
            fill_id  = r_lo_id;
            fill_wr  = r_lo_wr;
        end
    end

    always_comb begin
        o_rd_en = 1'b0;
        o_rd_addr = r_addr;
        if (r_state == S_IDLE) begin
            o_rd_addr = IW'(i_release_slot);
            o_rd_en   = i_valid && i_op && rel_in_range;
        end else if (r_state == S_SCAN) begin
            o_rd_en = !r_issue_done;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        n_cursor   = r_cursor;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_sel_idx;
        o_wr_id    = r_sel_id;
        o_wr_write = r_sel_wr;
        o_wr_refs  = r_sel_refs;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (!i_op) begin
                        n_state = S_SCAN;
                    end else if (rel_in_range) begin
                        n_state = S_REL;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend && (row_match || r_pidx == LAST_IDX)) begin
                    n_state = S_FIN;
                end
            end
            S_REL: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_OUT;
                n_res   = '0;
                if (r_op) begin
                    n_res.slot_index = r_rslot;
                    if (r_bad || r_sel_refs == '0) begin
                        n_res.status = rhc_pkg::ST_REL_NONE;
                    end else begin
                        o_wr_en         = 1'b1;
                        o_wr_refs       = refs_dec;
                        n_res.status    = rhc_pkg::ST_REL;
                        n_res.ref_after = rhc_pkg::REFOUT_W'(refs_dec);
                    end
                end else if (r_hit) begin
                    n_res.slot_index = rhc_pkg::SLOT_W'(r_sel_idx);
                    if (r_sel_refs == REF_MAX) begin
                        n_res.status    = rhc_pkg::ST_SAT;
                        n_res.ref_after = rhc_pkg::REFOUT_W'(r_sel_refs);
                    end else begin
                        o_wr_en         = 1'b1;
                        o_wr_refs       = refs_inc;
                        n_res.status    = rhc_pkg::ST_HIT;
                        n_res.ref_after = rhc_pkg::REFOUT_W'(refs_inc);
                    end
                end else begin
                    n_cursor = r_base;
                    if (fill_valid) begin
                        o_wr_en              = 1'b1;
                        o_wr_addr            = fill_idx;
                        o_wr_id              = r_key_id;
                        o_wr_write           = r_key_wr;
                        o_wr_refs            = REF_ONE;
                        n_res.status         = rhc_pkg::ST_FILL;
                        n_res.slot_index     = rhc_pkg::SLOT_W'(fill_idx);
                        n_res.ref_after      = rhc_pkg::REFOUT_W'(1);
                        n_res.replaced       = fill_vld;
                        n_res.replaced_id    = fill_vld ? fill_id : '0;
                        n_res.replaced_write = fill_vld && fill_wr;
                    end else begin
                        n_res.status = rhc_pkg::ST_FULL;
                    end
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= '0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_op         <= i_op;
            r_key_id     <= i_object_id;
            r_key_wr     <= i_want_write;
            r_rslot      <= i_release_slot;
            r_bad        <= !rel_in_range;
            r_base       <= base_next;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_pend       <= 1'b0;
            r_hit        <= 1'b0;
            r_have_hi    <= 1'b0;
            r_have_lo    <= 1'b0;
            r_sel_idx    <= IW'(i_release_slot);
        end
        if (r_state == S_REL) begin
            r_sel_refs <= i_rd_refs;
            r_sel_id   <= i_rd_id;
            r_sel_wr   <= i_rd_write;
        end
        if (r_state == S_SCAN) begin
            // Issue the next row read.
            r_pend <= !r_issue_done;
            if (!r_issue_done) begin
                r_pidx <= r_addr;
                if (r_addr == LAST_IDX) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            // Check the row that came back.
            if (r_pend) begin
                if (row_match) begin
                    r_hit      <= 1'b1;
                    r_sel_idx  <= r_pidx;
                    r_sel_refs <= i_rd_refs;
                    r_sel_id   <= i_rd_id;
                    r_sel_wr   <= i_rd_write;
                end else if (row_zero) begin
                    if (r_pidx >= r_base && !r_have_hi) begin
                        r_have_hi <= 1'b1;
                        r_hi_idx  <= r_pidx;
                        r_hi_vld  <= i_rd_valid;
                        r_hi_id   <= i_rd_id;
                        r_hi_wr   <= i_rd_write;
                    end
                    if (r_pidx < r_base && !r_have_lo) begin
                        r_have_lo <= 1'b1;
                        r_lo_idx  <= r_pidx;
                        r_lo_vld  <= i_rd_valid;
                        r_lo_id   <= i_rd_id;
                        r_lo_wr   <= i_rd_write;
                    end
                end
            end
        end
    end

    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;

    `RHC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !o_in_ready, "ready after accept")
    `RHC_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_res_valid && !i_out_free, o_res_valid && $stable(r_res), "result dropped while held")
    `RHC_ASSERT_SAME(a_full_clean, i_clk, i_rst_n, o_res_valid && r_res.status == rhc_pkg::ST_FULL, r_res.slot_index == '0 && r_res.ref_after == '0 && !r_res.replaced, "full result not clean")
    `RHC_ASSERT_SAME(a_fill_one, i_clk, i_rst_n, o_res_valid && r_res.status == rhc_pkg::ST_FILL, r_res.ref_after == rhc_pkg::REFOUT_W'(1), "fill count not one")

endmodule
